// ===== rtl/core/self_calibrating_sensor_normalizer_core_macros.svh =====
// Assertion macros used by the normalizer checker
`ifndef SELF_CALIBRATING_SENSOR_NORMALIZER_CORE_MACROS_SVH
`define SELF_CALIBRATING_SENSOR_NORMALIZER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SNRM_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("snrm: same-cycle property failed");

// next-cycle implication, disabled during reset
`define SNRM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("snrm: next-cycle property failed");

`endif

// ===== rtl/core/snrm_pkg.sv =====
// Types and constants of the sensor normalizer
package snrm_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int VAL_W       = SAMPLE_BITS + 2;
  localparam int OUT_W       = SAMPLE_BITS + 1;
  localparam int THR_W       = 15;
  localparam int LVL_W       = 11;
  localparam int DEAD_W      = 10;
  localparam int TDIV_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int Q_FRAC      = 10;
  localparam int TDIV_FRAC   = 4;
  localparam int DVD_W       = OUT_W + Q_FRAC;
  localparam int DVS_W       = OUT_W;
  localparam int CNT_W       = $clog2(DVD_W + 1);

  localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
  localparam int EMPTY_MIN   = 1 << SAMPLE_BITS;
  localparam int LEVEL_ONE   = 1 << Q_FRAC;
  localparam int SAT_Q       = LEVEL_ONE - 20;
  localparam int TDIV_ONE    = 1 << TDIV_FRAC;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_DIV   = 2'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CAL   = 2'd0,
    FUNC_FAST  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic                   load;
    logic [FUNC_W-1:0]      func;
    logic [SAMPLE_BITS-1:0] raw;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] last;
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
  } calib_t;

  typedef struct packed {
    logic rng_neg;
    logic d_zero;
    logic n_neg;
  } flags_t;

endpackage

// ===== rtl/core/snrm_if.sv =====
// Valid/ready channel interfaces of the sensor normalizer
interface snrm_in_if;
  logic                               valid;
  logic                               ready;
  logic [snrm_pkg::FUNC_W-1:0]        func;
  logic [snrm_pkg::SAMPLE_BITS-1:0]   raw_sample;

  modport source (output valid, output func, output raw_sample, input ready);
  modport sink (input valid, input func, input raw_sample, output ready);
endinterface

interface snrm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [snrm_pkg::OUT_W-1:0]  last_value;
  logic [snrm_pkg::OUT_W-1:0]         lowest_seen;
  logic signed [snrm_pkg::OUT_W-1:0]  highest_seen;
  logic signed [snrm_pkg::THR_W-1:0]  threshold;
  logic [snrm_pkg::LVL_W-1:0]         level;

  modport source (output valid, output last_value, output lowest_seen,
                  output highest_seen, output threshold, output level, input ready);
  modport sink (input valid, input last_value, input lowest_seen,
                input highest_seen, input threshold, input level, output ready);
endinterface

// ===== rtl/core/snrm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle
module snrm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [snrm_pkg::DVD_W-1:0]   dividend,
  input  logic [snrm_pkg::DVS_W-1:0]   divisor,
  output logic                         busy,
  output logic [snrm_pkg::DVD_W-1:0]   quot,
  output logic [snrm_pkg::DVS_W-1:0]   rem
);

  logic [snrm_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [snrm_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [snrm_pkg::DVS_W-1:0] dvs_r;
  logic [snrm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [snrm_pkg::DVS_W:0]   trial;
  logic                       qbit;

  always_comb begin
    trial    = {rem_r, dvd_r[snrm_pkg::DVD_W-1]};
    qbit     = (trial >= {1'b0, dvs_r});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = snrm_pkg::CNT_W'(snrm_pkg::DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[snrm_pkg::DVD_W-2:0], qbit};
      rem_nxt = qbit ? snrm_pkg::DVS_W'(trial - {1'b0, dvs_r})
                     : trial[snrm_pkg::DVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == snrm_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy = busy_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/snrm_calib.sv =====
// Last reading and min/max calibration registers
module snrm_calib (
  input  logic            clk,
  input  logic            rst_n,
  input  snrm_pkg::cmd_t  cmd,
  output snrm_pkg::calib_t cal
);

  snrm_pkg::calib_t                cal_r, cal_nxt;
  logic signed [snrm_pkg::VAL_W-1:0] inv;

  always_comb begin
    inv     = snrm_pkg::VAL_W'(snrm_pkg::FULL_SCALE) - snrm_pkg::VAL_W'(cmd.raw);
    cal_nxt = cal_r;
    if (cmd.load) begin
      case (cmd.func)
        snrm_pkg::FUNC_CAL: begin
          cal_nxt.last = inv;
          if (inv > cal_r.high) begin
            cal_nxt.high = inv;
          end
          if (inv < cal_r.low) begin
            cal_nxt.low = inv;
          end
        end
        snrm_pkg::FUNC_FAST: begin
          cal_nxt.last = inv;
        end
        snrm_pkg::FUNC_CLEAR: begin
          cal_nxt.last = '1;
          cal_nxt.high = '1;
          cal_nxt.low  = snrm_pkg::VAL_W'(snrm_pkg::EMPTY_MIN);
        end
        default: begin
          cal_nxt = cal_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.last <= '1;
      cal_r.high <= '1;
      cal_r.low  <= snrm_pkg::VAL_W'(snrm_pkg::EMPTY_MIN);
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

// ===== rtl/core/self_calibrating_sensor_normalizer_core.sv =====
// Top level of the self-calibrating sensor normalizer
//
// channel    dir   carries                                          flow
// in_item    in    func, raw_sample                                 valid/ready
// out_item   out   last_value, lowest_seen, highest_seen,           valid/ready
//                  threshold, level
// cfg        in    cfg_we, cfg_index, cfg_wdata                     write only
//
// An accepted item updates the calibration; in the load state both dividers are
// started in parallel on the new operands and give one quotient bit per cycle;
// when both are done and the output register is free, the result is loaded and
// the sequencer returns to idle with ready high. No new item is taken meanwhile.
// Reset is synchronous, active low, and restores the empty calibration.
// A stalled result blocks the next item in the dividers until it is taken.
module self_calibrating_sensor_normalizer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  snrm_in_if.sink                            in_item,
  snrm_out_if.source                         out_item,
  input  logic                               cfg_we,
  input  logic [snrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [snrm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  snrm_pkg::state_t                  state_r, state_nxt;
  snrm_pkg::cmd_t                    cmd;
  snrm_pkg::calib_t                  cal;
  snrm_pkg::flags_t                  flags_r, flags_nxt;

  logic [snrm_pkg::DEAD_W-1:0]       dead_r;
  logic [snrm_pkg::TDIV_W-1:0]       tdiv_r;

  logic signed [snrm_pkg::VAL_W-1:0] rng, rng_abs, nval, nn;
  logic [snrm_pkg::DVD_W-1:0]        thr_dvd, lvl_dvd;
  logic [snrm_pkg::DVS_W-1:0]        thr_dvs, lvl_dvs;
  logic                              div_start;
  logic                              thr_busy, lvl_busy;
  logic [snrm_pkg::DVD_W-1:0]        thr_q, lvl_q;
  logic [snrm_pkg::DVS_W-1:0]        thr_rem, lvl_rem;

  logic signed [snrm_pkg::THR_W:0]   thr_mag, thr_sgn, thr_sum;
  logic [snrm_pkg::DVD_W-1:0]        dead_ext;
  logic [snrm_pkg::LVL_W-1:0]        ldead, lvl_val;

  logic                              in_accept, load_out;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [snrm_pkg::OUT_W-1:0] last_r, high_r;
  logic [snrm_pkg::OUT_W-1:0]        low_r;
  logic signed [snrm_pkg::THR_W-1:0] thr_r;
  logic [snrm_pkg::LVL_W-1:0]        lvl_r;

  assign in_accept = in_item.valid && in_item.ready;
  assign cmd.load  = in_accept;
  assign cmd.func  = in_item.func;
  assign cmd.raw   = in_item.raw_sample;

  snrm_calib u_calib (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .cal   (cal)
  );

  // operand forming from the updated calibration
  always_comb begin
    rng      = cal.high - cal.low;
    nval     = cal.last - cal.low;
    rng_abs  = rng[snrm_pkg::VAL_W-1] ? -rng : rng;
    nn       = rng[snrm_pkg::VAL_W-1] ? -nval : nval;
    thr_dvd  = snrm_pkg::DVD_W'(rng_abs[snrm_pkg::OUT_W-1:0]) << snrm_pkg::TDIV_FRAC;
    thr_dvs  = (tdiv_r == '0) ? snrm_pkg::DVS_W'(snrm_pkg::TDIV_ONE)
                              : snrm_pkg::DVS_W'(tdiv_r);
    lvl_dvd  = snrm_pkg::DVD_W'(nn[snrm_pkg::OUT_W-1:0]) << snrm_pkg::Q_FRAC;
    lvl_dvs  = rng_abs[snrm_pkg::OUT_W-1:0];
    flags_nxt.rng_neg = rng[snrm_pkg::VAL_W-1];
    flags_nxt.d_zero  = (rng == '0);
    flags_nxt.n_neg   = nn[snrm_pkg::VAL_W-1];
  end

  snrm_div u_thr_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (thr_dvd),
    .divisor  (thr_dvs),
    .busy     (thr_busy),
    .quot     (thr_q),
    .rem      (thr_rem)
  );

  snrm_div u_lvl_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lvl_dvd),
    .divisor  (lvl_dvs),
    .busy     (lvl_busy),
    .quot     (lvl_q),
    .rem      (lvl_rem)
  );

  // result forming
  always_comb begin
    thr_mag  = {1'b0, thr_q[snrm_pkg::THR_W-1:0]};
    thr_sgn  = flags_r.rng_neg ? -thr_mag : thr_mag;
    thr_sum  = thr_sgn + (snrm_pkg::THR_W+1)'(cal.low);
    dead_ext = snrm_pkg::DVD_W'(dead_r);
    ldead    = snrm_pkg::LVL_W'(snrm_pkg::LEVEL_ONE) - snrm_pkg::LVL_W'(dead_r);
    if (flags_r.d_zero) begin
      lvl_val = (dead_r > snrm_pkg::DEAD_W'(snrm_pkg::SAT_Q)) ? ldead : '0;
    end else if (flags_r.n_neg || (lvl_q < dead_ext)) begin
      lvl_val = '0;
    end else if ((lvl_q > snrm_pkg::DVD_W'(snrm_pkg::SAT_Q)) ||
                 ((lvl_q == snrm_pkg::DVD_W'(snrm_pkg::SAT_Q)) && (lvl_rem != '0))) begin
      lvl_val = ldead;
    end else begin
      lvl_val = snrm_pkg::LVL_W'(lvl_q - dead_ext);
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    div_start      = 1'b0;
    load_out       = 1'b0;
    in_item.ready  = 1'b0;
    case (state_r)
      snrm_pkg::ST_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid) begin
          state_nxt = snrm_pkg::ST_LOAD;
        end
      end
      snrm_pkg::ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = snrm_pkg::ST_DIV;
      end
      snrm_pkg::ST_DIV: begin
        if (!thr_busy && !lvl_busy && (!out_valid_r || out_item.ready)) begin
          load_out  = 1'b1;
          state_nxt = snrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = snrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= snrm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      dead_r      <= '0;
      tdiv_r      <= snrm_pkg::TDIV_W'(snrm_pkg::TDIV_ONE);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          snrm_pkg::CFG_DEAD_ZONE: dead_r <= cfg_wdata[snrm_pkg::DEAD_W-1:0];
          snrm_pkg::CFG_THR_DIV:   tdiv_r <= cfg_wdata[snrm_pkg::TDIV_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      flags_r <= flags_nxt;
    end
    if (load_out) begin
      last_r <= cal.last[snrm_pkg::OUT_W-1:0];
      low_r  <= cal.low[snrm_pkg::OUT_W-1:0];
      high_r <= cal.high[snrm_pkg::OUT_W-1:0];
      thr_r  <= thr_sum[snrm_pkg::THR_W-1:0];
      lvl_r  <= lvl_val;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.last_value   = last_r;
  assign out_item.lowest_seen  = low_r;
  assign out_item.highest_seen = high_r;
  assign out_item.threshold    = thr_r;
  assign out_item.level        = lvl_r;

endmodule

// ===== rtl/core/snrm_checker.sv =====
// Port-level checker of the sensor normalizer and its bind
`include "self_calibrating_sensor_normalizer_core_macros.svh"

module snrm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [snrm_pkg::OUT_W-1:0]         out_last_value,
  input logic [snrm_pkg::OUT_W-1:0]         out_lowest_seen,
  input logic [snrm_pkg::OUT_W-1:0]         out_highest_seen,
  input logic [snrm_pkg::THR_W-1:0]         out_threshold,
  input logic [snrm_pkg::LVL_W-1:0]         out_level
);

  `SNRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_last_value) && $stable(out_lowest_seen) && $stable(out_highest_seen) && $stable(out_threshold) && $stable(out_level))
  `SNRM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `SNRM_ASSERT_SAME(a_empty_pair, clk, rst_n, out_valid, (out_lowest_seen == snrm_pkg::OUT_W'(snrm_pkg::EMPTY_MIN)) == (out_highest_seen == '1))
  `SNRM_ASSERT_SAME(a_level_max, clk, rst_n, out_valid, out_level <= snrm_pkg::LVL_W'(snrm_pkg::LEVEL_ONE))

endmodule

bind self_calibrating_sensor_normalizer_core snrm_checker u_snrm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_item.valid),
  .in_ready         (in_item.ready),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .out_last_value   (out_item.last_value),
  .out_lowest_seen  (out_item.lowest_seen),
  .out_highest_seen (out_item.highest_seen),
  .out_threshold    (out_item.threshold),
  .out_level        (out_item.level)
);
